FILE: rtl/pfplru_pkg.sv
package pfplru_pkg;

   // field widths fixed by the interface
   localparam int KIND_W     = 2;
   localparam int PAGE_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int FIDX_W     = 4;
   localparam int PIN_W      = 16;
   localparam int STAMP_W    = 48;

   // default pool size
   localparam int DEFAULT_NUM_FRAMES = 16;

   // pin count saturation value
   localparam logic [PIN_W-1:0] PIN_MAX = '1;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_FETCH = 2'd0,
      KIND_UNPIN = 2'd1,
      KIND_NEW   = 2'd2,
      KIND_FLUSH = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_HIT      = 3'd0,
      ST_LOADED   = 3'd1,
      ST_CREATED  = 3'd2,
      ST_DONE     = 3'd3,
      ST_NOFRAME  = 3'd4,
      ST_NOTFOUND = 3'd5
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_RESULT
   } state_type;

   // request transaction
   typedef struct packed {
      kind_type            kind;
      logic [PAGE_W-1:0]   page_id;
      logic                mark_dirty;
   } req_type;

   // response transaction
   typedef struct packed {
      status_type          status;
      logic [FIDX_W-1:0]   frame_index;
      logic [PAGE_W-1:0]   result_page_id;
      logic                writeback_request;
      logic [PAGE_W-1:0]   writeback_page_id;
      logic                load_request;
      logic                store_request;
   } rsp_type;

   // one frame table entry
   typedef struct packed {
      logic [PAGE_W-1:0]   page;
      logic                dirty;
      logic [PIN_W-1:0]    pins;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   // summary collected over one table scan
   typedef struct packed {
      logic                match_found;
      entry_type           match_entry;
      logic                vic_found;
      logic                vic_dirty;
      logic [PAGE_W-1:0]   vic_page;
      logic [PAGE_W-1:0]   max_page;
   } scan_sum_type;

endpackage

FILE: rtl/pfplru_frame_ram.sv
module pfplru_frame_ram #(
   parameter int NUM_FRAMES = pfplru_pkg::DEFAULT_NUM_FRAMES,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  pfplru_pkg::entry_type wr_data,
   input  logic                  rd_en,
   input  logic [IDX_W-1:0]      rd_addr,
   output pfplru_pkg::entry_type rd_data
);

   pfplru_pkg::entry_type frame_mem [NUM_FRAMES];
   pfplru_pkg::entry_type rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pfplru_scan_unit.sv
module pfplru_scan_unit #(
   parameter int NUM_FRAMES = pfplru_pkg::DEFAULT_NUM_FRAMES,
   parameter int IDX_W      = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              rd_valid,
   input  logic [IDX_W-1:0]                  rd_idx,
   input  pfplru_pkg::entry_type             rd_entry,
   input  logic [pfplru_pkg::PAGE_W-1:0]     page_id,
   output pfplru_pkg::scan_sum_type          sum,
   output logic [IDX_W-1:0]                  match_idx,
   output logic [IDX_W-1:0]                  vic_idx
);

   pfplru_pkg::scan_sum_type            sum_ff,       sum_in;
   logic [IDX_W-1:0]                    match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]                    vic_idx_ff,   vic_idx_in;
   logic [pfplru_pkg::STAMP_W-1:0]      vic_stamp_ff, vic_stamp_in;
   logic                                is_match;
   logic                                is_bigger;
   logic                                is_older;

   // per-entry compares: first match, largest page, oldest unpinned stamp
   assign is_match  = rd_valid && !sum_ff.match_found && (rd_entry.page == page_id);
   assign is_bigger = rd_valid && (rd_entry.page > sum_ff.max_page);
   assign is_older  = rd_valid && (rd_entry.pins == '0) &&
                      (!sum_ff.vic_found || (rd_entry.stamp < vic_stamp_ff));

   // accumulate one entry per cycle
   always_comb begin
      sum_in       = sum_ff;
      match_idx_in = match_idx_ff;
      vic_idx_in   = vic_idx_ff;
      vic_stamp_in = vic_stamp_ff;
      if (clear) begin
         sum_in.match_found = 1'b0;
         sum_in.vic_found   = 1'b0;
         sum_in.max_page    = '0;
      end else begin
         if (is_match) begin
            sum_in.match_found = 1'b1;
            sum_in.match_entry = rd_entry;
            match_idx_in       = rd_idx;
         end
         if (is_bigger) begin
            sum_in.max_page = rd_entry.page;
         end
         if (is_older) begin
            sum_in.vic_found = 1'b1;
            sum_in.vic_dirty = rd_entry.dirty;
            sum_in.vic_page  = rd_entry.page;
            vic_idx_in       = rd_idx;
            vic_stamp_in     = rd_entry.stamp;
         end
      end
   end

   // found flags under reset, accumulated payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff.match_found <= 1'b0;
         sum_ff.vic_found   <= 1'b0;
      end else begin
         sum_ff.match_found <= sum_in.match_found;
         sum_ff.vic_found   <= sum_in.vic_found;
      end
      sum_ff.match_entry <= sum_in.match_entry;
      sum_ff.vic_dirty   <= sum_in.vic_dirty;
      sum_ff.vic_page    <= sum_in.vic_page;
      sum_ff.max_page    <= sum_in.max_page;
      match_idx_ff       <= match_idx_in;
      vic_idx_ff         <= vic_idx_in;
      vic_stamp_ff       <= vic_stamp_in;
   end

   assign sum       = sum_ff;
   assign match_idx = match_idx_ff;
   assign vic_idx   = vic_idx_ff;

endmodule

FILE: rtl/page_frame_pool_lru_manager_top.sv
// channel   ports                                 direction   payload
// request   req_valid, req_stall, req_data        in          kind, page_id, mark_dirty
// response  rsp_valid, rsp_stall, rsp_data        out         status, frame_index, ids, requests
//
// for each transaction the single compare unit walks the occupied frames one memory
// read per cycle, then the update state writes the frame table and the result state
// hands the result over.
// reset empties the pool at once through the fill count; no clearing pass.
// req_stall is high while a transaction is in work; a stalled response sits in the
// output register and the next request is still taken behind it.
module page_frame_pool_lru_manager_top #(
   parameter int NUM_FRAMES = pfplru_pkg::DEFAULT_NUM_FRAMES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pfplru_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pfplru_pkg::rsp_type  rsp_data
);

   localparam int IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W = $clog2(NUM_FRAMES + 1);

   pfplru_pkg::state_type               state_ff,     state_in;
   pfplru_pkg::req_type                 req_ff;
   logic [CNT_W-1:0]                    fill_ff,      fill_in;
   logic [pfplru_pkg::STAMP_W-1:0]      tick_ff,      tick_in;
   logic [CNT_W-1:0]                    scan_addr_ff, scan_addr_in;
   logic                                rd_valid_ff;
   logic [IDX_W-1:0]                    rd_idx_ff;
   pfplru_pkg::rsp_type                 res_ff,       res_in;
   pfplru_pkg::rsp_type                 rsp_ff;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic                                req_accept;
   logic                                out_free;
   logic                                rd_en;
   logic                                scan_clear;
   logic                                upd_en;
   logic                                out_load;
   logic                                scan_done;

   pfplru_pkg::entry_type               rd_entry;
   pfplru_pkg::scan_sum_type            sum;
   logic [IDX_W-1:0]                    match_idx;
   logic [IDX_W-1:0]                    vic_idx;

   logic                                full;
   logic                                have_vic;
   logic [IDX_W-1:0]                    inst_idx;
   logic [pfplru_pkg::STAMP_W-1:0]      tick_next;
   logic [pfplru_pkg::PAGE_W-1:0]       new_pid;
   logic                                do_write;
   logic                                do_install;
   logic                                do_stamp;
   logic [IDX_W-1:0]                    wr_addr;
   pfplru_pkg::entry_type               wr_data;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_done  = (scan_addr_ff == fill_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfplru_pkg::S_IDLE: begin
            if (req_valid) state_in = pfplru_pkg::S_SCAN;
         end
         pfplru_pkg::S_SCAN: begin
            if (scan_done) state_in = pfplru_pkg::S_UPDATE;
         end
         pfplru_pkg::S_UPDATE: begin
            state_in = pfplru_pkg::S_RESULT;
         end
         pfplru_pkg::S_RESULT: begin
            if (out_free) state_in = pfplru_pkg::S_IDLE;
         end
         default: state_in = pfplru_pkg::S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      rd_en      = 1'b0;
      scan_clear = 1'b0;
      upd_en     = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         pfplru_pkg::S_IDLE: begin
            req_stall  = 1'b0;
            scan_clear = 1'b1;
         end
         pfplru_pkg::S_SCAN: begin
            rd_en = !scan_done;
         end
         pfplru_pkg::S_UPDATE: begin
            upd_en = 1'b1;
         end
         pfplru_pkg::S_RESULT: begin
            out_load = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // frame table
   pfplru_frame_ram #(
      .NUM_FRAMES (NUM_FRAMES),
      .IDX_W      (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (upd_en && do_write),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_addr_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   // shared compare unit
   pfplru_scan_unit #(
      .NUM_FRAMES (NUM_FRAMES),
      .IDX_W      (IDX_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .rd_valid  (rd_valid_ff),
      .rd_idx    (rd_idx_ff),
      .rd_entry  (rd_entry),
      .page_id   (req_ff.page_id),
      .sum       (sum),
      .match_idx (match_idx),
      .vic_idx   (vic_idx)
   );

   // victim choice: next empty frame while the pool fills, else the oldest unpinned
   assign full      = (fill_ff == CNT_W'(NUM_FRAMES));
   assign have_vic  = !full || sum.vic_found;
   assign inst_idx  = full ? vic_idx : fill_ff[IDX_W-1:0];
   assign tick_next = tick_ff + 1'b1;
   assign new_pid   = sum.max_page + 1'b1;

   // operation decode and table update
   always_comb begin
      res_in                = '0;
      res_in.status         = pfplru_pkg::ST_DONE;
      res_in.result_page_id = req_ff.page_id;
      wr_addr               = match_idx;
      wr_data               = sum.match_entry;
      do_write              = 1'b0;
      do_install            = 1'b0;
      do_stamp              = 1'b0;
      unique case (req_ff.kind)
         pfplru_pkg::KIND_FETCH: begin
            if (sum.match_found) begin
               do_write           = 1'b1;
               do_stamp           = 1'b1;
               wr_data.stamp      = tick_next;
               if (sum.match_entry.pins != pfplru_pkg::PIN_MAX) begin
                  wr_data.pins = sum.match_entry.pins + 1'b1;
               end
               res_in.status      = pfplru_pkg::ST_HIT;
               res_in.frame_index = pfplru_pkg::FIDX_W'(match_idx);
            end else if (have_vic) begin
               do_install          = 1'b1;
               res_in.status       = pfplru_pkg::ST_LOADED;
               res_in.load_request = 1'b1;
            end else begin
               res_in.status = pfplru_pkg::ST_NOFRAME;
            end
         end
         pfplru_pkg::KIND_UNPIN: begin
            if (sum.match_found) begin
               do_write = 1'b1;
               if (sum.match_entry.pins != '0) begin
                  wr_data.pins = sum.match_entry.pins - 1'b1;
               end
               wr_data.dirty      = sum.match_entry.dirty | req_ff.mark_dirty;
               res_in.frame_index = pfplru_pkg::FIDX_W'(match_idx);
            end else begin
               res_in.status = pfplru_pkg::ST_NOTFOUND;
            end
         end
         pfplru_pkg::KIND_NEW: begin
            res_in.result_page_id = new_pid;
            if (have_vic) begin
               do_install           = 1'b1;
               res_in.status        = pfplru_pkg::ST_CREATED;
               res_in.store_request = 1'b1;
            end else begin
               res_in.status = pfplru_pkg::ST_NOFRAME;
            end
         end
         pfplru_pkg::KIND_FLUSH: begin
            if (sum.match_found) begin
               do_write             = 1'b1;
               wr_data.dirty        = 1'b0;
               res_in.store_request = sum.match_entry.dirty;
               res_in.frame_index   = pfplru_pkg::FIDX_W'(match_idx);
            end else begin
               res_in.status = pfplru_pkg::ST_NOTFOUND;
            end
         end
         default: begin
            res_in.status = pfplru_pkg::ST_NOTFOUND;
         end
      endcase
      // install a fresh page into the chosen frame
      if (do_install) begin
         do_write           = 1'b1;
         do_stamp           = 1'b1;
         wr_addr            = inst_idx;
         wr_data.page       = (req_ff.kind == pfplru_pkg::KIND_NEW) ? new_pid : req_ff.page_id;
         wr_data.dirty      = 1'b0;
         wr_data.pins       = pfplru_pkg::PIN_W'(1);
         wr_data.stamp      = tick_next;
         res_in.frame_index = pfplru_pkg::FIDX_W'(inst_idx);
         if (full && sum.vic_dirty) begin
            res_in.writeback_request = 1'b1;
            res_in.writeback_page_id = sum.vic_page;
         end
      end
   end

   // fill count, access tick and scan address
   always_comb begin
      fill_in      = fill_ff;
      tick_in      = tick_ff;
      scan_addr_in = scan_addr_ff;
      if (upd_en && do_install && !full) fill_in = fill_ff + 1'b1;
      if (upd_en && do_stamp) tick_in = tick_next;
      if (scan_clear) begin
         scan_addr_in = '0;
      end else if (rd_en) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfplru_pkg::S_IDLE;
         fill_ff      <= '0;
         tick_ff      <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         tick_ff      <= tick_in;
         scan_addr_ff <= scan_addr_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff[IDX_W-1:0];
      if (req_accept) req_ff <= req_data;
      if (upd_en)     res_ff <= res_in;
      if (out_load)   rsp_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupancy never passes the pool size
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(NUM_FRAMES))
      else $error("fill count beyond pool size");

   // a no-frame result touches nothing on the disk side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == pfplru_pkg::ST_NOFRAME) |->
         (rsp_ff.frame_index == '0) && !rsp_ff.load_request &&
         !rsp_ff.store_request && !rsp_ff.writeback_request)
      else $error("no-frame result carries a request");

   // write-back only comes with an eviction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.writeback_request |->
         (rsp_ff.status == pfplru_pkg::ST_LOADED) || (rsp_ff.status == pfplru_pkg::ST_CREATED))
      else $error("write-back without eviction");

   // load only on a fetch miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.load_request |-> (rsp_ff.status == pfplru_pkg::ST_LOADED))
      else $error("load request outside a fetch miss");

endmodule
